FILE: sv/dirvsd_pkg.sv
// Shared types, constants and unit request structs for the dual IR speed detector.
`default_nettype none
package dirvsd_pkg;

  localparam int unsigned DivNumW = 37;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned DivCntW = 6;
  localparam int unsigned MacAccW = 38;
  localparam int unsigned MacCoefW = 17;
  localparam int unsigned MacOpW = 20;
  localparam int unsigned MacCntW = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 19;

  localparam logic [1:0] MODE_EMPTY = 2'd0;
  localparam logic [1:0] MODE_MEASURING = 2'd1;
  localparam logic [1:0] MODE_WAITING = 2'd2;
  localparam logic [1:0] MODE_DEAD_ZONE = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_DEAD_ZONE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ALPHA = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SPACING = 3'd3;

  localparam logic [19:0] SPEED_MAX = 20'hFFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [16:0] ALPHA_ONE = 17'h10000;

  typedef struct packed {
    logic [9:0]  from_sample;
    logic [9:0]  to_sample;
    logic [31:0] now_ms;
    logic        clear_report;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [18:0] from_filtered;
    logic [18:0] to_filtered;
    logic        car_measured;
    logic [19:0] car_speed;
    logic [15:0] car_total;
    logic [19:0] average_speed;
  } out_item_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
    logic [DivCntW-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic                start;
    logic [MacCoefW-1:0] coef_a;
    logic [MacOpW-1:0]   op_x;
    logic [MacCoefW-1:0] coef_b;
    logic [MacOpW-1:0]   op_y;
  } mac_req_t;

endpackage
`default_nettype wire

FILE: sv/dirvsd_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module dirvsd_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dirvsd_pkg::div_req_t          req,
  output logic                               done,
  output logic [dirvsd_pkg::DivNumW-1:0]     quotient
);

  logic [dirvsd_pkg::DivDenW-1:0] rem_r, rem_nxt;
  logic [dirvsd_pkg::DivNumW-1:0] num_r, num_nxt;
  logic [dirvsd_pkg::DivNumW-1:0] quo_r, quo_nxt;
  logic [dirvsd_pkg::DivDenW-1:0] den_r, den_nxt;
  logic [dirvsd_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [dirvsd_pkg::DivDenW:0]   trial;
  logic [dirvsd_pkg::DivDenW+1:0] diff;
  logic                           fits;

  always_comb begin
    trial = {rem_r, num_r[dirvsd_pkg::DivNumW-1]};
    diff = {1'b0, trial} - {2'b00, den_r};
    fits = ~diff[dirvsd_pkg::DivDenW+1];
    rem_nxt = rem_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = '0;
      num_nxt = req.dividend;
      quo_nxt = '0;
      den_nxt = req.divisor;
      cnt_nxt = req.iters;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // The partial remainder stays below the divisor, so it always fits 32 bits.
      rem_nxt = fits ? diff[dirvsd_pkg::DivDenW-1:0] : trial[dirvsd_pkg::DivDenW-1:0];
      num_nxt = {num_r[dirvsd_pkg::DivNumW-2:0], 1'b0};
      quo_nxt = {quo_r[dirvsd_pkg::DivNumW-2:0], fits};
      cnt_nxt = cnt_r - dirvsd_pkg::DivCntW'(1);
      if (cnt_r == dirvsd_pkg::DivCntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

FILE: sv/dirvsd_mac.sv
// Bit-serial sum of two products, one coefficient bit of each per cycle.
`default_nettype none
module dirvsd_mac (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dirvsd_pkg::mac_req_t          req,
  output logic                               done,
  output logic [dirvsd_pkg::MacAccW-1:0]     acc
);

  logic [dirvsd_pkg::MacAccW-1:0]  acc_r, acc_nxt;
  logic [dirvsd_pkg::MacCoefW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [dirvsd_pkg::MacOpW-1:0]   x_r, x_nxt, y_r, y_nxt;
  logic [dirvsd_pkg::MacCntW-1:0]  cnt_r, cnt_nxt;
  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;

  always_comb begin
    acc_nxt = acc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    x_nxt = x_r;
    y_nxt = y_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0;
      a_nxt = req.coef_a;
      b_nxt = req.coef_b;
      x_nxt = req.op_x;
      y_nxt = req.op_y;
      cnt_nxt = dirvsd_pkg::MacCntW'(dirvsd_pkg::MacCoefW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Coefficients are consumed most significant bit first.
      acc_nxt = {acc_r[dirvsd_pkg::MacAccW-2:0], 1'b0}
              + (a_r[dirvsd_pkg::MacCoefW-1] ? dirvsd_pkg::MacAccW'(x_r) : '0)
              + (b_r[dirvsd_pkg::MacCoefW-1] ? dirvsd_pkg::MacAccW'(y_r) : '0);
      a_nxt = {a_r[dirvsd_pkg::MacCoefW-2:0], 1'b0};
      b_nxt = {b_r[dirvsd_pkg::MacCoefW-2:0], 1'b0};
      cnt_nxt = cnt_r - dirvsd_pkg::MacCntW'(1);
      if (cnt_r == dirvsd_pkg::MacCntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign acc = acc_r;

endmodule
`default_nettype wire

FILE: sv/dual_ir_vehicle_speed_detector.sv
// Top level of the dual IR vehicle speed detector with its tick sequencer.
// The sequencer runs every step of a tick through one shared bit-serial divider (one quotient
// bit a cycle, for the two sample inversions and, on a tick that measures a car, the speed and
// the running mean) and one bit-serial multiply-add unit (for the two smoothing steps and the
// product); it then loads the output register and takes the next beat. A new beat is taken
// only once the previous tick has moved into the output register; the output register then
// waits for the downstream side while the next tick is worked on, and a tick that finishes
// while it is still full waits for it.
`default_nettype none
module dual_ir_vehicle_speed_detector (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire dirvsd_pkg::in_item_t              in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output dirvsd_pkg::out_item_t                  out_data,
  input  wire logic                              cfg_we,
  input  wire logic [dirvsd_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [dirvsd_pkg::CfgDataW-1:0]   cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INV_FROM = 4'd1;
  localparam logic [3:0] S_INV_TO = 4'd2;
  localparam logic [3:0] S_SMOOTH_FROM = 4'd3;
  localparam logic [3:0] S_SMOOTH_TO = 4'd4;
  localparam logic [3:0] S_SPEED = 4'd5;
  localparam logic [3:0] S_PRODUCT = 4'd6;
  localparam logic [3:0] S_MEAN = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [15:0] dead_zone_r;
  logic [16:0] alpha_r;
  logic [18:0] threshold_r;
  logic [15:0] spacing_r;

  logic [3:0]  state_r, state_nxt;
  dirvsd_pkg::in_item_t item_r, item_nxt;
  logic [18:0] from_avg_r, from_avg_nxt;
  logic [18:0] to_avg_r, to_avg_nxt;
  logic [18:0] from_inv_r, from_inv_nxt;
  logic [18:0] to_inv_r, to_inv_nxt;
  // Entry average as it stood before this tick, for the crossing test.
  logic [18:0] from_prev_r, from_prev_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] start_ms_r, start_ms_nxt;
  logic [31:0] wait_end_r, wait_end_nxt;
  logic [15:0] count_r, count_nxt;
  logic [19:0] mean_r, mean_nxt;
  logic        measured_r, measured_nxt;
  logic [19:0] speed_r, speed_nxt;
  logic        out_valid_r, out_valid_nxt;
  dirvsd_pkg::out_item_t out_data_r, out_data_nxt;

  dirvsd_pkg::div_req_t div_req;
  dirvsd_pkg::mac_req_t mac_req;
  logic                                 div_done;
  logic [dirvsd_pkg::DivNumW-1:0]       div_q;
  logic                                 mac_done;
  logic [dirvsd_pkg::MacAccW-1:0]       mac_acc;

  logic [16:0] alpha_eff;
  logic [16:0] alpha_rest;
  logic [9:0]  to_raw;
  logic [dirvsd_pkg::MacAccW-1:0] rounded;
  logic [18:0] smoothed;
  logic [31:0] dt;
  logic [29:0] speed_num;
  logic [dirvsd_pkg::MacAccW-1:0] total;
  logic        accept;

  dirvsd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (div_req),
    .done    (div_done),
    .quotient(div_q)
  );

  dirvsd_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mac_req),
    .done (mac_done),
    .acc  (mac_acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= 16'd500;
      alpha_r <= 17'd16384;
      threshold_r <= 19'd1024;
      spacing_r <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dirvsd_pkg::REG_DEAD_ZONE: dead_zone_r <= cfg_data[15:0];
        dirvsd_pkg::REG_ALPHA:     alpha_r <= cfg_data[16:0];
        dirvsd_pkg::REG_THRESHOLD: threshold_r <= cfg_data;
        dirvsd_pkg::REG_SPACING:   spacing_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign alpha_eff = (alpha_r > dirvsd_pkg::ALPHA_ONE) ? dirvsd_pkg::ALPHA_ONE : alpha_r;
  assign alpha_rest = dirvsd_pkg::ALPHA_ONE - alpha_eff;
  assign to_raw = (item_r.to_sample == 10'd0) ? 10'd1 : item_r.to_sample;
  assign rounded = mac_acc + dirvsd_pkg::MacAccW'(32768);
  assign smoothed = rounded[34:16];
  assign dt = (item_r.now_ms - start_ms_r == 32'd0) ? 32'd1 : item_r.now_ms - start_ms_r;
  // spacing * 36 * 256 is spacing * 8192 + spacing * 1024.
  assign speed_num = {1'b0, spacing_r, 13'd0} + {4'd0, spacing_r, 10'd0};
  assign total = mac_acc + dirvsd_pkg::MacAccW'(speed_r);

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    from_avg_nxt = from_avg_r;
    to_avg_nxt = to_avg_r;
    from_inv_nxt = from_inv_r;
    to_inv_nxt = to_inv_r;
    phase_nxt = phase_r;
    start_ms_nxt = start_ms_r;
    wait_end_nxt = wait_end_r;
    count_nxt = count_r;
    mean_nxt = mean_r;
    measured_nxt = measured_r;
    speed_nxt = speed_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    div_req = '0;
    mac_req = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          item_nxt = in_data;
          measured_nxt = 1'b0;
          speed_nxt = '0;
          if (in_data.clear_report) begin
            count_nxt = '0;
            mean_nxt = '0;
          end
          state_nxt = S_INV_FROM;
          div_req.start = 1'b1;
          div_req.dividend = {19'd262144, 18'd0};
          div_req.divisor = 32'(in_data.from_sample == 10'd0 ? 10'd1 : in_data.from_sample);
          div_req.iters = dirvsd_pkg::DivCntW'(19);
        end
      end
      S_INV_FROM: begin
        if (div_done) begin
          from_inv_nxt = div_q[18:0];
          state_nxt = S_INV_TO;
          div_req.start = 1'b1;
          div_req.dividend = {19'd262144, 18'd0};
          div_req.divisor = 32'(to_raw);
          div_req.iters = dirvsd_pkg::DivCntW'(19);
        end
      end
      S_INV_TO: begin
        if (div_done) begin
          to_inv_nxt = div_q[18:0];
          state_nxt = S_SMOOTH_FROM;
          mac_req.start = 1'b1;
          mac_req.coef_a = alpha_eff;
          mac_req.op_x = 20'(from_inv_r);
          mac_req.coef_b = alpha_rest;
          mac_req.op_y = 20'(from_avg_r);
        end
      end
      S_SMOOTH_FROM: begin
        if (mac_done) begin
          from_avg_nxt = smoothed;
          state_nxt = S_SMOOTH_TO;
          mac_req.start = 1'b1;
          mac_req.coef_a = alpha_eff;
          mac_req.op_x = 20'(to_inv_r);
          mac_req.coef_b = alpha_rest;
          mac_req.op_y = 20'(to_avg_r);
        end
      end
      S_SMOOTH_TO: begin
        if (mac_done) begin
          to_avg_nxt = smoothed;
          state_nxt = S_DONE;
          // from_avg_r already holds the new entry average, so the entry compare uses the
          // value saved when the beat was taken.
          unique case (phase_r)
            dirvsd_pkg::MODE_EMPTY: begin
              if (from_prev_r > threshold_r && from_avg_r < threshold_r) begin
                phase_nxt = dirvsd_pkg::MODE_MEASURING;
                start_ms_nxt = item_r.now_ms;
              end
            end
            dirvsd_pkg::MODE_MEASURING: begin
              if (to_avg_r > threshold_r && smoothed < threshold_r) begin
                phase_nxt = dirvsd_pkg::MODE_WAITING;
                state_nxt = S_SPEED;
                div_req.start = 1'b1;
                div_req.dividend = {speed_num, 7'd0};
                div_req.divisor = dt;
                div_req.iters = dirvsd_pkg::DivCntW'(30);
              end
            end
            dirvsd_pkg::MODE_WAITING: begin
              if (to_avg_r < threshold_r && smoothed > threshold_r) begin
                phase_nxt = dirvsd_pkg::MODE_DEAD_ZONE;
                wait_end_nxt = item_r.now_ms;
              end
            end
            dirvsd_pkg::MODE_DEAD_ZONE: begin
              if (item_r.now_ms - wait_end_r > 32'(dead_zone_r)) begin
                phase_nxt = dirvsd_pkg::MODE_EMPTY;
              end
            end
            default: ;
          endcase
        end
      end
      S_SPEED: begin
        if (div_done) begin
          speed_nxt = (div_q[29:20] != 10'd0) ? dirvsd_pkg::SPEED_MAX : div_q[19:0];
          measured_nxt = 1'b1;
          state_nxt = S_PRODUCT;
          mac_req.start = 1'b1;
          mac_req.coef_a = 17'(count_r);
          mac_req.op_x = mean_r;
        end
      end
      S_PRODUCT: begin
        if (mac_done) begin
          state_nxt = S_MEAN;
          div_req.start = 1'b1;
          div_req.dividend = total[dirvsd_pkg::DivNumW-1:0];
          div_req.divisor = 32'(17'(count_r) + 17'd1);
          div_req.iters = dirvsd_pkg::DivCntW'(dirvsd_pkg::DivNumW);
        end
      end
      S_MEAN: begin
        if (div_done) begin
          mean_nxt = div_q[19:0];
          if (count_r != dirvsd_pkg::COUNT_MAX) begin
            count_nxt = count_r + 16'd1;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.mode = phase_r;
          out_data_nxt.from_filtered = from_avg_r;
          out_data_nxt.to_filtered = to_avg_r;
          out_data_nxt.car_measured = measured_r;
          out_data_nxt.car_speed = speed_r;
          out_data_nxt.car_total = count_r;
          out_data_nxt.average_speed = mean_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign from_prev_nxt = (state_r == S_IDLE && accept) ? from_avg_r : from_prev_r;

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    from_inv_r <= from_inv_nxt;
    to_inv_r <= to_inv_nxt;
    speed_r <= speed_nxt;
    measured_r <= measured_nxt;
    out_data_r <= out_data_nxt;
    from_prev_r <= from_prev_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      from_avg_r <= '0;
      to_avg_r <= '0;
      phase_r <= dirvsd_pkg::MODE_EMPTY;
      start_ms_r <= '0;
      wait_end_r <= '0;
      count_r <= '0;
      mean_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      from_avg_r <= from_avg_nxt;
      to_avg_r <= to_avg_nxt;
      phase_r <= phase_nxt;
      start_ms_r <= start_ms_nxt;
      wait_end_r <= wait_end_nxt;
      count_r <= count_nxt;
      mean_r <= mean_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_speed_only_when_measured: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.car_measured |-> out_data_r.car_speed == 20'd0)
    else $error("speed reported without a measurement");

  a_measure_enters_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.car_measured |-> out_data_r.mode == dirvsd_pkg::MODE_WAITING)
    else $error("measured beat not in waiting mode");

  a_div_done_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_INV_FROM || state_r == S_INV_TO || state_r == S_SPEED ||
                 state_r == S_MEAN)
    else $error("divider finished outside a divide step");

  a_mac_done_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == S_SMOOTH_FROM || state_r == S_SMOOTH_TO || state_r == S_PRODUCT)
    else $error("multiplier finished outside a multiply step");

endmodule
`default_nettype wire
